// File: design/zpfft_pkg.sv
// Shared types, constants and twiddle generation for the zero-padded FFT.
`timescale 1ns / 1ps
package zpfft_pkg;

    localparam int POINTS_DEF      = 128;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int TW_FRAC_DEF     = 14;

    localparam int RES_W    = 25;
    localparam int SAMPLE_W = 16;
    localparam int CFG_W    = 8;
    localparam int VC_RESET = 128;
    localparam int DRAIN    = 3;

    localparam logic MEM_PING = 1'b0;
    localparam logic MEM_PONG = 1'b1;

    localparam logic [63:0] PI_Q32  = 64'h0000_0003_243F_6A89;
    localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;

    typedef struct packed {
        logic load_we;
        logic clear;
        logic fft_issue;
        logic src_sel;
        logic dst_sel;
        logic out_load;
        logic odd_present;
        logic run_last;
    } dp_cmd_t;

    function automatic logic [63:0] mul_q32(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[95:32];
    endfunction

    function automatic logic [63:0] sin_q32(input logic [63:0] x);
        logic [63:0] t;
        logic [63:0] s;
        t = x;
        s = x;
        t = mul_q32(mul_q32(t, x), x) / 64'd6;   s = s - t;
        t = mul_q32(mul_q32(t, x), x) / 64'd20;  s = s + t;
        t = mul_q32(mul_q32(t, x), x) / 64'd42;  s = s - t;
        t = mul_q32(mul_q32(t, x), x) / 64'd72;  s = s + t;
        t = mul_q32(mul_q32(t, x), x) / 64'd110; s = s - t;
        t = mul_q32(mul_q32(t, x), x) / 64'd156; s = s + t;
        t = mul_q32(mul_q32(t, x), x) / 64'd210; s = s - t;
        return s;
    endfunction

    function automatic logic [63:0] cos_q32(input logic [63:0] x);
        logic [63:0] t;
        logic [63:0] c;
        t = ONE_Q32;
        c = ONE_Q32;
        t = mul_q32(mul_q32(t, x), x) / 64'd2;   c = c - t;
        t = mul_q32(mul_q32(t, x), x) / 64'd12;  c = c + t;
        t = mul_q32(mul_q32(t, x), x) / 64'd30;  c = c - t;
        t = mul_q32(mul_q32(t, x), x) / 64'd56;  c = c + t;
        t = mul_q32(mul_q32(t, x), x) / 64'd90;  c = c - t;
        t = mul_q32(mul_q32(t, x), x) / 64'd132; c = c + t;
        t = mul_q32(mul_q32(t, x), x) / 64'd182; c = c - t;
        return c;
    endfunction

    function automatic logic [63:0] to_twiddle(input logic [63:0] v, input int frac);
        return (v + (64'd1 << (31 - frac))) >> (32 - frac);
    endfunction

    // {re, im} of exp(-2*pi*i*m/2^lg), each a 32-bit two's complement word
    function automatic logic [63:0] twiddle_pair(input int m, input int lg, input int frac);
        logic [63:0] quarter;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] c;
        logic [63:0] s;
        logic [63:0] ca;
        logic [63:0] sa;
        logic [63:0] cc;
        logic [63:0] ss;
        logic [63:0] wi;
        quarter = 64'd1 << (lg - 2);
        q = (64'(m) >> (lg - 2)) & 64'd3;
        r = 64'(m) & (quarter - 64'd1);
        if ((r << 1) <= quarter) begin
            x = (PI_Q32 * (r << 1) + (64'd1 << (lg - 1))) >> lg;
            c = cos_q32(x);
            s = sin_q32(x);
        end else begin
            x = (PI_Q32 * ((quarter - r) << 1) + (64'd1 << (lg - 1))) >> lg;
            c = sin_q32(x);
            s = cos_q32(x);
        end
        ca = to_twiddle(c, frac);
        sa = to_twiddle(s, frac);
        case (q)
            64'd0: begin cc = ca;  ss = sa;  end
            64'd1: begin cc = -sa; ss = ca;  end
            64'd2: begin cc = -ca; ss = -sa; end
            default: begin cc = sa; ss = -ca; end
        endcase
        wi = -ss;
        return {cc[31:0], wi[31:0]};
    endfunction

endpackage

// File: design/zpfft_ctrl.sv
// Controller: frame loading, stage sequencing and result readout.
`timescale 1ns / 1ps
module zpfft_ctrl #(
    parameter int POINTS = zpfft_pkg::POINTS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           cfg_valid,
    input  logic [zpfft_pkg::CFG_W-1:0]    cfg_data,
    output zpfft_pkg::dp_cmd_t             cmd,
    output logic [$clog2(POINTS)-1:0]      rd_a,
    output logic [$clog2(POINTS)-1:0]      rd_b,
    output logic [$clog2(POINTS)-1:0]      tw_idx,
    output logic [$clog2(POINTS)-1:0]      wr_addr,
    output logic [$clog2(POINTS)-1:0]      load_addr
);
    localparam int L   = $clog2(POINTS);
    localparam int AW  = L;
    localparam int STW = $clog2(L);
    localparam int SHW = STW + 1;
    localparam int VW  = (L + 1 > zpfft_pkg::CFG_W) ? L + 1 : zpfft_pkg::CFG_W;
    localparam int CNW = L + 2;
    localparam logic [CNW-1:0] CNT_ISSUE = CNW'(POINTS);
    localparam logic [CNW-1:0] CNT_END   = CNW'(POINTS + zpfft_pkg::DRAIN - 1);
    localparam logic RES_MEM = ((L - 1) % 2 == 0) ? zpfft_pkg::MEM_PONG : zpfft_pkg::MEM_PING;

    typedef enum logic [4:0] {
        ST_LOAD  = 5'b00001,
        ST_FFT   = 5'b00010,
        ST_OREAD = 5'b00100,
        ST_OLOAD = 5'b01000,
        ST_OSEND = 5'b10000
    } state_t;

    state_t                         state_reg, state_next;
    logic [zpfft_pkg::CFG_W-1:0]    vcount_reg;
    logic [L:0]                     sidx_reg, sidx_next;
    logic [STW-1:0]                 stage_reg, stage_next;
    logic [CNW-1:0]                 cnt_reg, cnt_next;
    logic [L-2:0]                   j_reg, j_next;

    logic [L:0]    vc_eff;
    logic [L-1:0]  nres;
    logic          odd_here;
    logic          last_here;
    logic          in_acc;
    logic [AW-1:0] o, n, k, rmask, dmask, fft_a;
    logic [STW-1:0] sh;
    logic [SHW-1:0] sh_a;

    function automatic logic [AW-1:0] bit_rev(input logic [AW-1:0] v);
        logic [AW-1:0] r;
        for (int d = 0; d < AW; d++) begin
            r[d] = v[AW-1-d];
        end
        return r;
    endfunction

    always_comb begin
        logic [L+1:0] vc_inc;
        if (VW'(vcount_reg) > VW'(POINTS)) begin
            vc_eff = (L + 1)'(POINTS);
        end else begin
            vc_eff = (L + 1)'(vcount_reg);
        end
        vc_inc    = {1'b0, vc_eff} + (L + 2)'(1);
        nres      = vc_inc[L:1];
        odd_here  = ({1'b0, j_reg, 1'b1} < vc_eff);
        last_here = (({1'b0, j_reg} + L'(1)) == nres);
    end

    // butterfly addressing for the current stage
    always_comb begin
        o     = cnt_reg[AW-1:0];
        sh    = STW'(L - 1) - stage_reg;
        sh_a  = SHW'(L) - SHW'(stage_reg);
        rmask = (AW'(1) << sh) - AW'(1);
        dmask = (AW'(1) << stage_reg) - AW'(1);
        n     = o >> sh;
        k     = o & rmask;
        fft_a = ((n & dmask) << sh_a) | (k << 1);
    end

    assign s_tready  = (state_reg == ST_LOAD);
    assign m_tvalid  = (state_reg == ST_OSEND);
    assign in_acc    = s_tvalid && s_tready;
    assign load_addr = bit_rev(sidx_reg[AW-1:0]);
    assign wr_addr   = o;
    assign tw_idx    = o & ~rmask;

    always_comb begin
        state_next = state_reg;
        sidx_next  = sidx_reg;
        stage_next = stage_reg;
        cnt_next   = cnt_reg;
        j_next     = j_reg;
        cmd        = '0;
        rd_a       = fft_a;
        rd_b       = fft_a | AW'(1);
        unique case (state_reg)
            ST_LOAD: begin
                if (in_acc) begin
                    cmd.load_we = (sidx_reg < vc_eff);
                    if (sidx_reg < (L + 1)'(POINTS)) begin
                        sidx_next = sidx_reg + (L + 1)'(1);
                    end
                    if (s_tlast) begin
                        sidx_next = '0;
                        if (vc_eff == '0) begin
                            cmd.clear = 1'b1;
                        end else begin
                            state_next = ST_FFT;
                            stage_next = '0;
                            cnt_next   = '0;
                        end
                    end
                end
            end
            ST_FFT: begin
                cmd.fft_issue = (cnt_reg < CNT_ISSUE);
                cmd.src_sel   = stage_reg[0] ? zpfft_pkg::MEM_PONG : zpfft_pkg::MEM_PING;
                cmd.dst_sel   = ~cmd.src_sel;
                if (cnt_reg == CNT_END) begin
                    cnt_next = '0;
                    if (stage_reg == STW'(L - 1)) begin
                        state_next = ST_OREAD;
                        j_next     = '0;
                    end else begin
                        stage_next = stage_reg + STW'(1);
                    end
                end else begin
                    cnt_next = cnt_reg + CNW'(1);
                end
            end
            ST_OREAD: begin
                rd_a        = {j_reg, 1'b0};
                rd_b        = {j_reg, 1'b1};
                cmd.src_sel = RES_MEM;
                state_next  = ST_OLOAD;
            end
            ST_OLOAD: begin
                cmd.out_load    = 1'b1;
                cmd.odd_present = odd_here;
                cmd.run_last    = last_here;
                state_next      = ST_OSEND;
            end
            ST_OSEND: begin
                if (m_tready) begin
                    if (last_here) begin
                        cmd.clear  = 1'b1;
                        state_next = ST_LOAD;
                    end else begin
                        j_next     = j_reg + (L - 1)'(1);
                        state_next = ST_OREAD;
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_LOAD;
            vcount_reg <= zpfft_pkg::CFG_W'(zpfft_pkg::VC_RESET);
            sidx_reg   <= '0;
            stage_reg  <= '0;
            cnt_reg    <= '0;
            j_reg      <= '0;
        end else begin
            state_reg <= state_next;
            sidx_reg  <= sidx_next;
            stage_reg <= stage_next;
            cnt_reg   <= cnt_next;
            j_reg     <= j_next;
            if (cfg_valid) begin
                vcount_reg <= cfg_data;
            end
        end
    end

endmodule

// File: design/zpfft_dp.sv
// Datapath: ping/pong stores, butterfly pipeline and output register.
`timescale 1ns / 1ps
module zpfft_dp #(
    parameter int POINTS      = zpfft_pkg::POINTS_DEF,
    parameter int SAMPLE_BITS = zpfft_pkg::SAMPLE_BITS_DEF,
    parameter int TW_FRAC     = zpfft_pkg::TW_FRAC_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  zpfft_pkg::dp_cmd_t            cmd,
    input  logic [$clog2(POINTS)-1:0]     rd_a,
    input  logic [$clog2(POINTS)-1:0]     rd_b,
    input  logic [$clog2(POINTS)-1:0]     tw_idx,
    input  logic [$clog2(POINTS)-1:0]     wr_addr,
    input  logic [$clog2(POINTS)-1:0]     load_addr,
    input  logic [2*zpfft_pkg::SAMPLE_W-1:0] s_tdata,
    output logic [103:0]                  m_tdata,
    output logic                          m_tuser,
    output logic                          m_tlast
);
    localparam int L    = $clog2(POINTS);
    localparam int AW   = L;
    localparam int RW   = zpfft_pkg::RES_W;
    localparam int EW   = 2 * RW;
    localparam int TW_W = TW_FRAC + 2;
    localparam int PW   = RW + TW_W;
    localparam int SUMW = PW + 2;
    localparam int SW   = zpfft_pkg::SAMPLE_W;
    localparam logic [SW-1:0] SMASK =
        (SAMPLE_BITS >= SW) ? {SW{1'b1}} : SW'((1 << SAMPLE_BITS) - 1);
    localparam logic signed [SUMW-1:0] RES_MAX = SUMW'((1 << (RW - 1)) - 1);
    localparam logic signed [SUMW-1:0] RES_MIN = -SUMW'(1 << (RW - 1));

    logic signed [TW_W-1:0] tw_re_rom [POINTS];
    logic signed [TW_W-1:0] tw_im_rom [POINTS];

    for (genvar g = 0; g < POINTS; g++) begin : g_tw
        localparam logic [63:0] PAIR = zpfft_pkg::twiddle_pair(g, L, TW_FRAC);
        assign tw_re_rom[g] = PAIR[32+TW_W-1:32];
        assign tw_im_rom[g] = PAIR[TW_W-1:0];
    end

    logic [EW-1:0]     ping_mem [POINTS];
    logic [EW-1:0]     pong_mem [POINTS];
    logic [POINTS-1:0] ping_vld_reg;

    // read stage
    logic [EW-1:0]          ping_a_reg, ping_b_reg, pong_a_reg, pong_b_reg;
    logic signed [TW_W-1:0] twr_reg, twi_reg;
    logic                   v1_reg, src1_reg, dst1_reg;
    logic [AW-1:0]          wa1_reg;
    // multiply stage
    logic signed [RW-1:0]   a2_re_reg, a2_im_reg;
    logic signed [PW-1:0]   mrr_reg, mii_reg, mri_reg, mir_reg;
    logic                   v2_reg, dst2_reg;
    logic [AW-1:0]          wa2_reg;
    // combine stage
    logic signed [RW-1:0]   a3_re_reg, a3_im_reg;
    logic signed [PW:0]     pr_reg, pi_reg;
    logic                   v3_reg, dst3_reg;
    logic [AW-1:0]          wa3_reg;

    logic [EW-1:0]        a_sel, b_sel;
    logic signed [RW-1:0] b_re, b_im;
    logic [RW-1:0]        res_re, res_im;
    logic [EW-1:0]        sample_word;
    logic                 ping_we, pong_we;
    logic [AW-1:0]        ping_wa;
    logic [EW-1:0]        ping_wd;

    function automatic logic [RW-1:0] round_add_sat(input logic signed [PW:0] p,
                                                    input logic signed [RW-1:0] a);
        logic signed [SUMW-1:0] u;
        logic signed [SUMW-1:0] s;
        u = SUMW'(p) + SUMW'(1 << (TW_FRAC - 1));
        s = (u >>> TW_FRAC) + SUMW'(a);
        if (s > RES_MAX) begin
            return RW'(RES_MAX);
        end else if (s < RES_MIN) begin
            return RW'(RES_MIN);
        end
        return s[RW-1:0];
    endfunction

    assign a_sel = src1_reg ? pong_a_reg : ping_a_reg;
    assign b_sel = src1_reg ? pong_b_reg : ping_b_reg;
    assign b_re  = b_sel[RW-1:0];
    assign b_im  = b_sel[EW-1:RW];

    assign res_re = round_add_sat(pr_reg, a3_re_reg);
    assign res_im = round_add_sat(pi_reg, a3_im_reg);

    assign sample_word = {(RW - SW)'(0), s_tdata[2*SW-1:SW] & SMASK,
                          (RW - SW)'(0), s_tdata[SW-1:0] & SMASK};

    always_comb begin
        ping_we = 1'b0;
        ping_wa = wa3_reg;
        ping_wd = {res_im, res_re};
        if (cmd.load_we) begin
            ping_we = 1'b1;
            ping_wa = load_addr;
            ping_wd = sample_word;
        end else if (v3_reg && dst3_reg == zpfft_pkg::MEM_PING) begin
            ping_we = 1'b1;
        end
        pong_we = v3_reg && dst3_reg == zpfft_pkg::MEM_PONG;
    end

    always_ff @(posedge aclk) begin
        if (ping_we) begin
            ping_mem[ping_wa] <= ping_wd;
        end
        if (pong_we) begin
            pong_mem[wa3_reg] <= {res_im, res_re};
        end
        // ping entries not written this frame read as zero
        ping_a_reg <= ping_vld_reg[rd_a] ? ping_mem[rd_a] : '0;
        ping_b_reg <= ping_vld_reg[rd_b] ? ping_mem[rd_b] : '0;
        pong_a_reg <= pong_mem[rd_a];
        pong_b_reg <= pong_mem[rd_b];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ping_vld_reg <= '0;
        end else if (cmd.clear) begin
            ping_vld_reg <= '0;
        end else if (ping_we) begin
            ping_vld_reg[ping_wa] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.fft_issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        twr_reg  <= tw_re_rom[tw_idx];
        twi_reg  <= tw_im_rom[tw_idx];
        src1_reg <= cmd.src_sel;
        dst1_reg <= cmd.dst_sel;
        wa1_reg  <= wr_addr;

        a2_re_reg <= a_sel[RW-1:0];
        a2_im_reg <= a_sel[EW-1:RW];
        mrr_reg   <= b_re * twr_reg;
        mii_reg   <= b_im * twi_reg;
        mri_reg   <= b_re * twi_reg;
        mir_reg   <= b_im * twr_reg;
        dst2_reg  <= dst1_reg;
        wa2_reg   <= wa1_reg;

        a3_re_reg <= a2_re_reg;
        a3_im_reg <= a2_im_reg;
        pr_reg    <= (PW + 1)'(mrr_reg) - (PW + 1)'(mii_reg);
        pi_reg    <= (PW + 1)'(mri_reg) + (PW + 1)'(mir_reg);
        dst3_reg  <= dst2_reg;
        wa3_reg   <= wa2_reg;
    end

    // result register, loaded in the cycle after the pair read
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata <= {4'd0,
                        cmd.odd_present ? b_sel[EW-1:RW] : RW'(0),
                        cmd.odd_present ? b_sel[RW-1:0]  : RW'(0),
                        a_sel[EW-1:RW], a_sel[RW-1:0]};
            m_tuser <= cmd.odd_present;
            m_tlast <= cmd.run_last;
        end
    end

endmodule

// File: design/zero_padded_fft_128_core.sv
// Load one sample per cycle while s_tready is high; the transform runs log2(POINTS)
// butterfly stages, one butterfly output per cycle through the butterfly pipeline,
// with a drain between stages; readout steps through read, load and send states
// for each bin pair, waiting in send for m_tready.
// aresetn is synchronous, active low: clears control state and the ping store
// valid bits, and sets valid_count to 128.
`timescale 1ns / 1ps
module zero_padded_fft_128_core #(
    parameter int POINTS      = zpfft_pkg::POINTS_DEF,
    parameter int SAMPLE_BITS = zpfft_pkg::SAMPLE_BITS_DEF,
    parameter int TW_FRAC     = zpfft_pkg::TW_FRAC_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,   // sample_re, sample_im
    input  logic                          s_tlast,   // frame_end
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [103:0]                  m_tdata,   // even_bin_re, even_bin_im,
                                                     // odd_bin_re, odd_bin_im
    output logic                          m_tuser,   // odd_present
    output logic                          m_tlast,   // run_last
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [zpfft_pkg::CFG_W-1:0]   cfg_data   // valid_count
);
    localparam int AW = $clog2(POINTS);

    zpfft_pkg::dp_cmd_t cmd;
    logic [AW-1:0] rd_a, rd_b, tw_idx, wr_addr, load_addr;

    assign cfg_ready = 1'b1;

    zpfft_ctrl #(
        .POINTS (POINTS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .rd_a      (rd_a),
        .rd_b      (rd_b),
        .tw_idx    (tw_idx),
        .wr_addr   (wr_addr),
        .load_addr (load_addr)
    );

    zpfft_dp #(
        .POINTS      (POINTS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .TW_FRAC     (TW_FRAC)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .rd_a      (rd_a),
        .rd_b      (rd_b),
        .tw_idx    (tw_idx),
        .wr_addr   (wr_addr),
        .load_addr (load_addr),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the zero-padded 128-point FFT core: frames in, bin pairs out.
`timescale 1ns / 1ps
module testbench;
    localparam int RES_W       = zpfft_pkg::RES_W;
    localparam int CFG_W       = zpfft_pkg::CFG_W;
    localparam int TW_FRAC_DEF = zpfft_pkg::TW_FRAC_DEF;
    localparam int VC_RESET    = zpfft_pkg::VC_RESET;

    localparam int NPT  = 128;
    localparam int LGN  = 7;
    localparam int SETTLE = 1500;

    typedef struct packed {
        logic [15:0] re;
        logic [15:0] im;
        logic        last;
    } sample_t;

    typedef struct packed {
        logic [RES_W-1:0] even_re;
        logic [RES_W-1:0] even_im;
        logic [RES_W-1:0] odd_re;
        logic [RES_W-1:0] odd_im;
        logic             odd_present;
        logic             run_last;
    } bin_pair_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [31:0]  s_tdata;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;
    logic         m_tuser;
    logic         m_tlast;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [CFG_W-1:0] cfg_data;

    zero_padded_fft_128_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    sample_t   pending_samples[$];
    bin_pair_t bins_due[$];
    int        mismatches = 0;
    int        items_sent = 0;

    // predictor state
    longint    load_re[NPT];
    longint    load_im[NPT];
    longint    work_re[2][NPT];
    longint    work_im[2][NPT];
    longint    tw_re[NPT];
    longint    tw_im[NPT];
    int        load_index;
    int        count_reg;

    logic      hold_trigger;
    logic      hold_done;
    int        hold_left;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #30_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
        return (a * b) >> 32;
    endfunction

    function automatic longint unsigned series_sin(longint unsigned x);
        longint unsigned t;
        longint unsigned acc;
        t = x;
        acc = x;
        for (int k = 1; k <= 7; k++) begin
            t = qmul(qmul(t, x), x) / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) acc = acc - t; else acc = acc + t;
        end
        return acc;
    endfunction

    function automatic longint unsigned series_cos(longint unsigned x);
        longint unsigned t;
        longint unsigned acc;
        t = 64'h1_0000_0000;
        acc = 64'h1_0000_0000;
        for (int k = 1; k <= 7; k++) begin
            t = qmul(qmul(t, x), x) / longint'((2 * k - 1) * (2 * k));
            if (k % 2 == 1) acc = acc - t; else acc = acc + t;
        end
        return acc;
    endfunction

    function automatic longint quantize_tw(longint unsigned v);
        return longint'((v + (64'd1 << (31 - TW_FRAC_DEF))) >> (32 - TW_FRAC_DEF));
    endfunction

    function automatic void build_twiddles();
        longint unsigned pi32;
        longint unsigned x;
        longint          cq;
        longint          sq;
        longint          cr;
        longint          sr;
        int              quarter;
        int              quad;
        int              rem;
        pi32 = 64'h3_243F_6A89;
        quarter = NPT / 4;
        for (int m = 0; m < NPT; m++) begin
            quad = (m / quarter) % 4;
            rem = m % quarter;
            if (2 * rem <= quarter) begin
                x = (pi32 * 2 * rem + NPT / 2) / NPT;
                cq = quantize_tw(series_cos(x));
                sq = quantize_tw(series_sin(x));
            end else begin
                x = (pi32 * 2 * (quarter - rem) + NPT / 2) / NPT;
                cq = quantize_tw(series_sin(x));
                sq = quantize_tw(series_cos(x));
            end
            case (quad)
                0: begin cr = cq;  sr = sq;  end
                1: begin cr = -sq; sr = cq;  end
                2: begin cr = -cq; sr = -sq; end
                default: begin cr = sq; sr = -cq; end
            endcase
            tw_re[m] = cr;
            tw_im[m] = -sr;
        end
    endfunction

    function automatic longint clamp25(longint v);
        if (v > 64'sd16777215) return 64'sd16777215;
        if (v < -64'sd16777216) return -64'sd16777216;
        return v;
    endfunction

    function automatic int bitrev7(int v);
        int r;
        r = 0;
        for (int d = 0; d < LGN; d++) r = (r << 1) | ((v >> d) & 1);
        return r;
    endfunction

    // Run the seven butterfly stages; returns the index of the buffer holding the bins.
    function automatic int transform_frame();
        int src;
        int d;
        int r;
        int base;
        int m;
        longint br;
        longint bi;
        longint pr;
        longint pim;
        src = 0;
        for (int i = 0; i < NPT; i++) begin
            work_re[0][i] = load_re[i];
            work_im[0][i] = load_im[i];
        end
        d = 1;
        r = NPT / 2;
        while (d < NPT) begin
            for (int n = 0; n < 2 * d; n++) begin
                base = (n % d) * 2 * r;
                m = (n * r) % NPT;
                for (int k = 0; k < r; k++) begin
                    br = work_re[src][base + 2 * k + 1];
                    bi = work_im[src][base + 2 * k + 1];
                    pr = br * tw_re[m] - bi * tw_im[m];
                    pim = br * tw_im[m] + bi * tw_re[m];
                    // add half an lsb, then floor: round to nearest, ties up
                    work_re[1 - src][n * r + k] = clamp25(work_re[src][base + 2 * k] +
                        ((pr + 8192) >>> TW_FRAC_DEF));
                    work_im[1 - src][n * r + k] = clamp25(work_im[src][base + 2 * k] +
                        ((pim + 8192) >>> TW_FRAC_DEF));
                end
            end
            src = 1 - src;
            d = d * 2;
            r = r / 2;
        end
        return src;
    endfunction

    function automatic void predict_sample(sample_t smp);
        int        vc;
        int        npairs;
        int        res;
        bin_pair_t bp;
        vc = (count_reg > NPT) ? NPT : count_reg;
        if (load_index < vc) begin
            load_re[bitrev7(load_index)] = longint'(smp.re);
            load_im[bitrev7(load_index)] = longint'(smp.im);
        end
        if (load_index < NPT) load_index++;
        if (!smp.last) return;
        res = transform_frame();
        npairs = (vc + 1) / 2;
        for (int j = 0; j < npairs; j++) begin
            bp.even_re = work_re[res][2 * j][RES_W-1:0];
            bp.even_im = work_im[res][2 * j][RES_W-1:0];
            bp.odd_present = (2 * j + 1 < vc);
            bp.odd_re = bp.odd_present ? work_re[res][2 * j + 1][RES_W-1:0] : '0;
            bp.odd_im = bp.odd_present ? work_im[res][2 * j + 1][RES_W-1:0] : '0;
            bp.run_last = (j + 1 == npairs);
            bins_due.push_back(bp);
        end
        for (int i = 0; i < NPT; i++) begin
            load_re[i] = 0;
            load_im[i] = 0;
        end
        load_index = 0;
    endfunction

    task automatic report_mismatch(string what, logic [RES_W-1:0] got, logic [RES_W-1:0] want);
        mismatches++;
        $display("[%0t] %s: got %h expected %h", $realtime, what, got, want);
    endtask

    // sender: pops pending samples, inserts random gaps
    int gap_left;
    always @(posedge aclk) begin
        sample_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left > 0 || pending_samples.size() == 0) begin
                s_tvalid <= 1'b0;
                if (gap_left > 0) gap_left <= gap_left - 1;
            end else begin
                nxt = pending_samples.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {nxt.im, nxt.re};
                s_tlast <= nxt.last;
                case ($urandom_range(0, 19))
                    0: gap_left <= $urandom_range(20, 80);
                    1, 2, 3, 4: gap_left <= $urandom_range(1, 3);
                    default: gap_left <= 0;
                endcase
            end
        end
    end

    // long receiver hold-off, counted on its own
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_trigger && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= 4000;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // receiver: predict on input transactions, check output transactions
    int rdy_gap;
    always @(posedge aclk) begin
        bin_pair_t got;
        bin_pair_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rdy_gap <= 0;
        end else begin
            if (s_tvalid && s_tready)
                predict_sample('{re: s_tdata[15:0], im: s_tdata[31:16], last: s_tlast});
            if (m_tvalid && m_tready) begin
                got.even_re = m_tdata[24:0];
                got.even_im = m_tdata[49:25];
                got.odd_re = m_tdata[74:50];
                got.odd_im = m_tdata[99:75];
                got.odd_present = m_tuser;
                got.run_last = m_tlast;
                if (bins_due.size() == 0) begin
                    mismatches++;
                    $display("[%0t] unexpected bin pair %h", $realtime, m_tdata);
                end else begin
                    want = bins_due.pop_front();
                    if (got.even_re !== want.even_re)
                        report_mismatch("even_bin_re", got.even_re, want.even_re);
                    if (got.even_im !== want.even_im)
                        report_mismatch("even_bin_im", got.even_im, want.even_im);
                    if (got.odd_re !== want.odd_re)
                        report_mismatch("odd_bin_re", got.odd_re, want.odd_re);
                    if (got.odd_im !== want.odd_im)
                        report_mismatch("odd_bin_im", got.odd_im, want.odd_im);
                    if (got.odd_present !== want.odd_present)
                        report_mismatch("odd_present", RES_W'(got.odd_present),
                                        RES_W'(want.odd_present));
                    if (got.run_last !== want.run_last)
                        report_mismatch("run_last", RES_W'(got.run_last),
                                        RES_W'(want.run_last));
                end
            end
            if ((hold_trigger && !hold_done) || hold_left > 0) begin
                m_tready <= 1'b0;
            end else if (rdy_gap > 0) begin
                rdy_gap <= rdy_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                case ($urandom_range(0, 19))
                    0: rdy_gap <= $urandom_range(20, 60);
                    1, 2, 3: rdy_gap <= $urandom_range(1, 3);
                    default: rdy_gap <= 0;
                endcase
            end
        end
    end

    task automatic push_sample(logic [15:0] re, logic [15:0] im, logic last);
        pending_samples.push_back('{re: re, im: im, last: last});
        items_sent++;
    endtask

    function automatic logic [15:0] rand_part();
        case ($urandom_range(0, 9))
            0: return 16'hFFFF;
            1: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic wait_idle();
        do @(posedge aclk);
        while (pending_samples.size() != 0 || s_tvalid || bins_due.size() != 0);
        // a frame with zero count yields nothing, so let any transform finish
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_count(int value);
        cfg_valid <= 1'b1;
        cfg_data <= CFG_W'(value);
        do @(posedge aclk);
        while (!(cfg_valid && cfg_ready));
        count_reg = value;
        cfg_valid <= 1'b0;
    endtask

    // One frame: mostly exactly min(count, 128) samples (at least one), sometimes short or with surplus.
    task automatic push_frame(int cnt);
        int len;
        int eff;
        eff = (cnt > NPT) ? NPT : cnt;
        case ($urandom_range(0, 9))
            0: len = (eff > 1) ? $urandom_range(1, eff - 1) : 1;
            1: len = eff + $urandom_range(1, 5);
            default: len = (eff == 0) ? 1 : eff;
        endcase
        for (int i = 0; i < len; i++) push_sample(rand_part(), rand_part(), i == len - 1);
    endtask

    initial begin
        int vc;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        hold_trigger = 1'b0;
        build_twiddles();
        for (int i = 0; i < NPT; i++) begin
            load_re[i] = 0;
            load_im[i] = 0;
        end
        load_index = 0;
        count_reg = VC_RESET;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, surplus samples, odd count, early frame end, zero count
        write_count(4);
        push_sample(16'hFFFF, 16'hFFFF, 1'b0);
        push_sample(16'h0000, 16'h0000, 1'b0);
        push_sample(16'hFFFF, 16'h0000, 1'b0);
        push_sample(16'h0000, 16'hFFFF, 1'b0);
        push_sample(16'h5555, 16'hAAAA, 1'b0);
        push_sample(16'hAAAA, 16'h5555, 1'b1);
        wait_idle();
        write_count(3);
        push_sample(16'h8000, 16'h0001, 1'b0);
        push_sample(16'h7FFF, 16'hFFFE, 1'b0);
        push_sample(16'h0001, 16'h8000, 1'b1);
        wait_idle();
        write_count(5);
        push_sample(16'h1234, 16'hFEDC, 1'b0);
        push_sample(16'hFFFF, 16'hFFFF, 1'b1);
        wait_idle();
        write_count(0);
        push_sample(16'hFFFF, 16'hFFFF, 1'b0);
        push_sample(16'hFFFF, 16'hFFFF, 1'b1);
        wait_idle();
        write_count(1);
        push_sample(16'hFFFF, 16'h0000, 1'b1);
        push_sample(16'h0000, 16'hFFFF, 1'b1);
        wait_idle();

        // full count with a long receiver hold-off so the input backs up
        write_count(128);
        hold_trigger = 1'b1;
        push_frame(128);
        push_frame(128);
        wait_idle();
        write_count(255);
        push_frame(255);
        wait_idle();
        write_count(2);
        for (int f = 0; f < 4; f++) push_frame(2);
        wait_idle();

        while (items_sent < 420) begin
            vc = $urandom_range(1, 9);
            write_count(vc);
            for (int f = 0; f < 3; f++) push_frame(vc);
            wait_idle();
        end

        do @(posedge aclk);
        while (pending_samples.size() != 0 || s_tvalid || bins_due.size() != 0);
        repeat (SETTLE) @(posedge aclk);
        if (mismatches == 0 && bins_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
